/* rtl/core/wcc_pkg.sv */
// Shared constants, types and codes for the window cross-correlation core.
`timescale 1ns / 1ps

package wcc_pkg;

    localparam int WINDOW_SIZE = 32;
    localparam int WIN_CELLS   = WINDOW_SIZE * WINDOW_SIZE;
    localparam int MAP_SIDE    = 2 * WINDOW_SIZE;
    localparam int MAP_CELLS   = MAP_SIDE * MAP_SIDE;

    localparam int IDX_W     = (WINDOW_SIZE > 2) ? $clog2(WINDOW_SIZE) : 1;
    localparam int MAP_IDX_W = $clog2(MAP_SIDE);
    localparam int ADDR_W    = $clog2(WIN_CELLS);
    localparam int LC_W      = $clog2(WIN_CELLS + 1);
    localparam int BIDX_W    = IDX_W + 3;

    localparam int PIX_W   = 8;
    localparam int MEAN_W  = 12;
    localparam int VAL_W   = 13;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int ACC_W   = PROD_W + $clog2(WIN_CELLS) + 1;
    localparam int SC_RAW  = ACC_W + $clog2(MAP_CELLS) + 2;
    localparam int SC_W    = (SC_RAW > 48) ? SC_RAW : 48;
    localparam int CORR_W  = 47;
    localparam int IDX_OUT_W = 6;

    localparam logic signed [CORR_W-1:0] CORR_MAX = {1'b0, {(CORR_W-1){1'b1}}};
    localparam logic signed [CORR_W-1:0] CORR_MIN = {1'b1, {(CORR_W-1){1'b0}}};

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic CFG_MEAN_A = 1'b0;
    localparam logic CFG_MEAN_B = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_SCALE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear;
        logic en;
    } mac_ctrl_t;

endpackage

/* rtl/core/wcc_mac.sv */
// Mean removal and multiply-accumulate unit shared by every term of a map entry.
`timescale 1ns / 1ps

module wcc_mac
    import wcc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mac_ctrl_t                ctrl,
    input  logic [PIX_W-1:0]         pixel_a,
    input  logic [PIX_W-1:0]         pixel_b,
    input  logic [MEAN_W-1:0]        mean_a,
    input  logic [MEAN_W-1:0]        mean_b,
    output logic signed [ACC_W-1:0]  acc
);

    logic signed [VAL_W-1:0]  val_a;
    logic signed [VAL_W-1:0]  val_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     prod_valid_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    always_comb begin
        val_a     = $signed({1'b0, pixel_a, 4'b0000}) - $signed({1'b0, mean_a});
        val_b     = $signed({1'b0, pixel_b, 4'b0000}) - $signed({1'b0, mean_b});
        prod_next = PROD_W'(val_a) * PROD_W'(val_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end else if (ctrl.clear) begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end else begin
            prod_valid_reg <= ctrl.en;
            if (prod_valid_reg) begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign acc = acc_reg;

endmodule

/* rtl/core/window_cross_correlation_2d_core.sv */
// Top level of the window cross-correlation core: window stores, sequencer, output register.
`timescale 1ns / 1ps

// Load transactions (operation 0) write one pixel pair into the A and B window stores and
// do not drop s_ready; after WINDOW_SIZE squared loads the window pair is complete and the
// next load starts a new pair. A read transaction (operation 1) returns the next entry of
// the 2L by 2L correlation map in row-major order, wrapping after the last entry. A read
// before the pair is complete is taken without a stall and returns nothing. A read that
// returns an entry keeps s_ready low after it is accepted, while the single multiply-
// accumulate unit walks every A pixel once, one term per cycle, fed by one read port per
// window store, and then passes through the drain, scale and output states; the entry is
// valid at the output when s_ready rises again. The result waits in the output register,
// so loads are taken while it is unclaimed; a further read holds in its output state,
// with s_ready low, until the previous entry is claimed. Configuration writes
// (mean_a, mean_b) must be made while the core is idle.
module window_cross_correlation_2d_core
    import wcc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     cfg_wr_en,
    input  logic                     cfg_index,
    input  logic [MEAN_W-1:0]        cfg_wr_data,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_operation,
    input  logic [PIX_W-1:0]         s_pixel_a,
    input  logic [PIX_W-1:0]         s_pixel_b,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [CORR_W-1:0] m_corr_value,
    output logic [IDX_OUT_W-1:0]     m_row_index,
    output logic [IDX_OUT_W-1:0]     m_col_index,
    output logic                     m_last_of_map
);

    logic [PIX_W-1:0] mem_a [WIN_CELLS];
    logic [PIX_W-1:0] mem_b [WIN_CELLS];

    state_t                   state_reg, state_next;
    logic [MEAN_W-1:0]        mean_a_reg, mean_b_reg;
    logic [LC_W-1:0]          load_count_reg, load_count_next;
    logic                     loaded_reg, loaded_next;
    logic [MAP_IDX_W-1:0]     kr_reg, kr_next;
    logic [MAP_IDX_W-1:0]     kc_reg, kc_next;
    logic [IDX_W-1:0]         r_reg, r_next;
    logic [IDX_W-1:0]         c_reg, c_next;
    logic [ADDR_W-1:0]        a_addr_reg, a_addr_next;
    logic                     drain_reg, drain_next;
    logic                     rd_valid_reg, rd_valid_next;
    logic [PIX_W-1:0]         a_q_reg, b_q_reg;
    logic signed [SC_W-1:0]   scaled_reg, scaled_next;

    logic                     m_valid_reg, m_valid_next;
    logic signed [CORR_W-1:0] m_corr_reg, m_corr_next;
    logic [IDX_OUT_W-1:0]     m_row_reg, m_row_next;
    logic [IDX_OUT_W-1:0]     m_col_reg, m_col_next;
    logic                     m_last_reg, m_last_next;

    logic                     s_fire;
    logic                     wr_en;
    logic [LC_W-1:0]          load_base;
    logic signed [BIDX_W-1:0] br, bc;
    logic                     b_in_range;
    logic [ADDR_W-1:0]        b_addr;
    logic                     map_last;
    logic [31:0]              kr_ext, kc_ext;
    logic signed [ACC_W-1:0]  acc;
    mac_ctrl_t                mac_ctrl;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        br = BIDX_W'(r_reg) + BIDX_W'(WINDOW_SIZE - 1) - BIDX_W'(kr_reg);
        bc = BIDX_W'(c_reg) + BIDX_W'(WINDOW_SIZE - 1) - BIDX_W'(kc_reg);
        b_in_range = !br[BIDX_W-1] && (br < BIDX_W'(WINDOW_SIZE))
                  && !bc[BIDX_W-1] && (bc < BIDX_W'(WINDOW_SIZE));
        b_addr = ADDR_W'(br[IDX_W-1:0] * WINDOW_SIZE + bc[IDX_W-1:0]);
        map_last = (kr_reg == MAP_IDX_W'(MAP_SIDE - 1)) && (kc_reg == MAP_IDX_W'(MAP_SIDE - 1));
        kr_ext = 32'(kr_reg);
        kc_ext = 32'(kc_reg);
        load_base = loaded_reg ? '0 : load_count_reg;
    end

    always_comb begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        loaded_next     = loaded_reg;
        kr_next         = kr_reg;
        kc_next         = kc_reg;
        r_next          = r_reg;
        c_next          = c_reg;
        a_addr_next     = a_addr_reg;
        drain_next      = drain_reg;
        rd_valid_next   = 1'b0;
        scaled_next     = scaled_reg;
        mac_ctrl        = '0;
        wr_en           = 1'b0;
        m_valid_next    = m_valid_reg && !m_ready;
        m_corr_next     = m_corr_reg;
        m_row_next      = m_row_reg;
        m_col_next      = m_col_reg;
        m_last_next     = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_operation == OP_LOAD) begin
                    // a load after a complete pair starts a new pair
                    if (loaded_reg) begin
                        kr_next = '0;
                        kc_next = '0;
                    end
                    load_count_next = load_base;
                    if (load_base < LC_W'(WIN_CELLS)) begin
                        wr_en           = 1'b1;
                        load_count_next = load_base + 1'b1;
                    end
                    loaded_next = (load_count_next >= LC_W'(WIN_CELLS));
                end else if (s_fire && loaded_reg) begin
                    mac_ctrl.clear = 1'b1;
                    r_next         = '0;
                    c_next         = '0;
                    a_addr_next    = '0;
                    state_next     = ST_RUN;
                end
            end
            ST_RUN: begin
                rd_valid_next = b_in_range;
                a_addr_next   = a_addr_reg + 1'b1;
                if (c_reg == IDX_W'(WINDOW_SIZE - 1)) begin
                    c_next = '0;
                    r_next = r_reg + 1'b1;
                end else begin
                    c_next = c_reg + 1'b1;
                end
                if (a_addr_reg == ADDR_W'(WIN_CELLS - 1)) begin
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait for the last term to pass the read and product registers
                drain_next = 1'b1;
                if (drain_reg) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                scaled_next = SC_W'(acc) * $signed(SC_W'(MAP_CELLS));
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (scaled_reg > SC_W'(CORR_MAX)) begin
                        m_corr_next = CORR_MAX;
                    end else if (scaled_reg < SC_W'(CORR_MIN)) begin
                        m_corr_next = CORR_MIN;
                    end else begin
                        m_corr_next = scaled_reg[CORR_W-1:0];
                    end
                    m_row_next  = kr_ext[IDX_OUT_W-1:0];
                    m_col_next  = kc_ext[IDX_OUT_W-1:0];
                    m_last_next = map_last;
                    // advance the map position, wrap after the last entry
                    if (kc_reg == MAP_IDX_W'(MAP_SIDE - 1)) begin
                        kc_next = '0;
                        kr_next = map_last ? '0 : kr_reg + 1'b1;
                    end else begin
                        kc_next = kc_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        mac_ctrl.en = rd_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mean_a_reg     <= '0;
            mean_b_reg     <= '0;
            load_count_reg <= '0;
            loaded_reg     <= 1'b0;
            kr_reg         <= '0;
            kc_reg         <= '0;
            r_reg          <= '0;
            c_reg          <= '0;
            a_addr_reg     <= '0;
            drain_reg      <= 1'b0;
            rd_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            loaded_reg     <= loaded_next;
            kr_reg         <= kr_next;
            kc_reg         <= kc_next;
            r_reg          <= r_next;
            c_reg          <= c_next;
            a_addr_reg     <= a_addr_next;
            drain_reg      <= drain_next;
            rd_valid_reg   <= rd_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MEAN_A: mean_a_reg <= cfg_wr_data;
                    CFG_MEAN_B: mean_b_reg <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        scaled_reg <= scaled_next;
        m_corr_reg <= m_corr_next;
        m_row_reg  <= m_row_next;
        m_col_reg  <= m_col_next;
        m_last_reg <= m_last_next;
    end

    // window stores: one write port for loads, one read port each for the walk
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_a[load_base[ADDR_W-1:0]] <= s_pixel_a;
            mem_b[load_base[ADDR_W-1:0]] <= s_pixel_b;
        end
        if (state_reg == ST_RUN) begin
            a_q_reg <= mem_a[a_addr_reg];
            b_q_reg <= mem_b[b_addr];
        end
    end

    wcc_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .pixel_a (a_q_reg),
        .pixel_b (b_q_reg),
        .mean_a  (mean_a_reg),
        .mean_b  (mean_b_reg),
        .acc     (acc)
    );

    assign m_valid       = m_valid_reg;
    assign m_corr_value  = m_corr_reg;
    assign m_row_index   = m_row_reg;
    assign m_col_index   = m_col_reg;
    assign m_last_of_map = m_last_reg;

endmodule

/* verif/window_cross_correlation_2d_core_test.sv */
// Self-checking testbench for the window cross-correlation core: directed table, then random phases.
`timescale 1ns / 1ps

module window_cross_correlation_2d_core_test;
    import wcc_pkg::*;

    localparam int QUIET_LIMIT = 8 * (WIN_CELLS + 64);

    typedef struct {
        logic signed [CORR_W-1:0] value;
        logic [IDX_OUT_W-1:0]     row;
        logic [IDX_OUT_W-1:0]     col;
        logic                     last;
    } map_entry_t;

    typedef enum logic [1:0] {
        ROW_MEANS,
        ROW_ITEM,
        ROW_FILL
    } row_kind_t;

    typedef struct {
        row_kind_t                kind;
        logic                     op;
        logic [PIX_W-1:0]         pa;
        logic [PIX_W-1:0]         pb;
        logic [MEAN_W-1:0]        ma;
        logic [MEAN_W-1:0]        mb;
        bit                       typed;
        bit                       has_result;
        logic signed [CORR_W-1:0] value;
        logic [IDX_OUT_W-1:0]     row;
        logic [IDX_OUT_W-1:0]     col;
    } directed_row_t;

    logic                     aclk;
    logic                     aresetn = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic                     cfg_index = CFG_MEAN_A;
    logic [MEAN_W-1:0]        cfg_wr_data = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_operation = OP_LOAD;
    logic [PIX_W-1:0]         s_pixel_a = '0;
    logic [PIX_W-1:0]         s_pixel_b = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [CORR_W-1:0] m_corr_value;
    logic [IDX_OUT_W-1:0]     m_row_index;
    logic [IDX_OUT_W-1:0]     m_col_index;
    logic                     m_last_of_map;

    // Predictor state
    logic [PIX_W-1:0]  win_a_pix [WIN_CELLS];
    logic [PIX_W-1:0]  win_b_pix [WIN_CELLS];
    int unsigned       fill_count = 0;
    int unsigned       map_pos = 0;
    bit                pair_ready = 1'b0;
    logic [MEAN_W-1:0] mean_a_q = '0;
    logic [MEAN_W-1:0] mean_b_q = '0;

    map_entry_t    pending_entries [$];
    directed_row_t directed_rows [20];
    int            errors = 0;
    int            idle_pct = 0;
    int            stall_pct = 0;
    int            quiet_cycles = 0;

    window_cross_correlation_2d_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_pixel_a     (s_pixel_a),
        .s_pixel_b     (s_pixel_b),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_corr_value  (m_corr_value),
        .m_row_index   (m_row_index),
        .m_col_index   (m_col_index),
        .m_last_of_map (m_last_of_map)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Entry (kr, kc): sum of a'[r][c] * b'[r+L-1-kr][c+L-1-kc], scaled by the map size.
    function automatic logic signed [CORR_W-1:0] map_value(input int kr, input int kc);
        longint acc;
        longint av;
        longint bv;
        int     br;
        int     bc;
        acc = 0;
        for (int r = 0; r < WINDOW_SIZE; r++) begin
            br = r + WINDOW_SIZE - 1 - kr;
            if (br >= 0 && br < WINDOW_SIZE) begin
                for (int c = 0; c < WINDOW_SIZE; c++) begin
                    bc = c + WINDOW_SIZE - 1 - kc;
                    if (bc >= 0 && bc < WINDOW_SIZE) begin
                        av = longint'(win_a_pix[r * WINDOW_SIZE + c]) * 16 - longint'(mean_a_q);
                        bv = longint'(win_b_pix[br * WINDOW_SIZE + bc]) * 16 - longint'(mean_b_q);
                        acc += av * bv;
                    end
                end
            end
        end
        acc = acc * MAP_CELLS;
        if (acc > longint'(CORR_MAX)) acc = longint'(CORR_MAX);
        if (acc < longint'(CORR_MIN)) acc = longint'(CORR_MIN);
        return acc[CORR_W-1:0];
    endfunction

    function automatic void correlate_step(input logic op, input logic [PIX_W-1:0] pa,
                                           input logic [PIX_W-1:0] pb,
                                           output bit got, output map_entry_t e);
        got = 1'b0;
        e = '{default: '0};
        if (op == OP_LOAD) begin
            // a load after a complete pair starts a new one
            if (pair_ready) begin
                pair_ready = 1'b0;
                fill_count = 0;
                map_pos = 0;
            end
            if (fill_count < WIN_CELLS) begin
                win_a_pix[fill_count] = pa;
                win_b_pix[fill_count] = pb;
                fill_count++;
            end
            if (fill_count >= WIN_CELLS) pair_ready = 1'b1;
        end else if (pair_ready) begin
            if (map_pos >= MAP_CELLS) map_pos = 0;
            e.row   = IDX_OUT_W'(map_pos / MAP_SIDE);
            e.col   = IDX_OUT_W'(map_pos % MAP_SIDE);
            e.value = map_value(map_pos / MAP_SIDE, map_pos % MAP_SIDE);
            e.last  = (map_pos == MAP_CELLS - 1);
            map_pos = e.last ? 0 : map_pos + 1;
            got = 1'b1;
        end
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        if ($urandom_range(3) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
        return PIX_W'($urandom);
    endfunction

    // Called at a rising edge; returns at the edge where the transaction is taken.
    task automatic send_item(input logic op, input logic [PIX_W-1:0] pa,
                             input logic [PIX_W-1:0] pb,
                             output bit got, output map_entry_t e);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_pixel_a   <= pa;
        s_pixel_b   <= pb;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        correlate_step(op, pa, pb, got, e);
    endtask

    task automatic send_checked(input logic op, input logic [PIX_W-1:0] pa,
                                input logic [PIX_W-1:0] pb);
        bit         got;
        map_entry_t e;
        send_item(op, pa, pb, got, e);
        if (got) pending_entries.push_back(e);
    endtask

    // Drop valid, drain every expected entry, then let the core settle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_entries.size() != 0) @(posedge aclk);
        repeat (WIN_CELLS + 16) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [MEAN_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_MEAN_A) mean_a_q = val;
        else mean_b_q = val;
        @(posedge aclk);
    endtask

    task automatic set_means(input logic [MEAN_W-1:0] ma, input logic [MEAN_W-1:0] mb);
        wait_idle();
        write_reg(CFG_MEAN_A, ma);
        write_reg(CFG_MEAN_B, mb);
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin : check_results
        map_entry_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_entries.size() == 0) begin
                $error("unexpected entry row %0d col %0d", m_row_index, m_col_index);
                errors++;
            end else begin
                want = pending_entries.pop_front();
                if (m_corr_value !== want.value) begin
                    $error("corr_value expected %0d actual %0d", want.value, m_corr_value);
                    errors++;
                end
                if (m_row_index !== want.row) begin
                    $error("row_index expected %0d actual %0d", want.row, m_row_index);
                    errors++;
                end
                if (m_col_index !== want.col) begin
                    $error("col_index expected %0d actual %0d", want.col, m_col_index);
                    errors++;
                end
                if (m_last_of_map !== want.last) begin
                    $error("last_of_map expected %0d actual %0d", want.last, m_last_of_map);
                    errors++;
                end
            end
        end
    end

    // Watchdog: any transaction on either channel restarts the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        directed_row_t r;
        bit            got;
        map_entry_t    e;
        int            n_reads;

        // Uniform 255 windows with zero means give (kc+1) * 4080^2 * 4096 along row 0;
        // zero windows with full-scale means give (kc+1) * 4095^2 * 4096.
        directed_rows = '{
            '{ROW_MEANS, OP_LOAD, 8'd0,   8'd0,   12'd0,    12'd0,    1'b0, 1'b0,
              47'sd0, 6'd0, 6'd0},
            '{ROW_ITEM,  OP_READ, 8'd0,   8'd0,   12'd0,    12'd0,    1'b1, 1'b0,
              47'sd0, 6'd0, 6'd0},
            '{ROW_ITEM,  OP_LOAD, 8'd255, 8'd255, 12'd0,    12'd0,    1'b0, 1'b0,
              47'sd0, 6'd0, 6'd0},
            '{ROW_ITEM,  OP_READ, 8'd255, 8'd255, 12'd0,    12'd0,    1'b1, 1'b0,
              47'sd0, 6'd0, 6'd0},
            '{ROW_FILL,  OP_LOAD, 8'd255, 8'd255, 12'd0,    12'd0,    1'b0, 1'b0,
              47'sd0, 6'd0, 6'd0},
            '{ROW_ITEM,  OP_READ, 8'd0,   8'd0,   12'd0,    12'd0,    1'b1, 1'b1,
              47'sd68183654400, 6'd0, 6'd0},
            '{ROW_ITEM,  OP_READ, 8'd255, 8'd255, 12'd0,    12'd0,    1'b1, 1'b1,
              47'sd136367308800, 6'd0, 6'd1},
            '{ROW_MEANS, OP_LOAD, 8'd0,   8'd0,   12'd4095, 12'd4095, 1'b0, 1'b0,
              47'sd0, 6'd0, 6'd0},
            '{ROW_ITEM,  OP_READ, 8'd0,   8'd0,   12'd0,    12'd0,    1'b1, 1'b1,
              47'sd2764800, 6'd0, 6'd2},
            '{ROW_MEANS, OP_LOAD, 8'd0,   8'd0,   12'd4095, 12'd0,    1'b0, 1'b0,
              47'sd0, 6'd0, 6'd0},
            '{ROW_ITEM,  OP_READ, 8'd0,   8'd0,   12'd0,    12'd0,    1'b1, 1'b1,
              -47'sd1002700800, 6'd0, 6'd3},
            '{ROW_ITEM,  OP_READ, 8'd0,   8'd0,   12'd0,    12'd0,    1'b0, 1'b0,
              47'sd0, 6'd0, 6'd0},
            '{ROW_ITEM,  OP_LOAD, 8'd0,   8'd0,   12'd0,    12'd0,    1'b0, 1'b0,
              47'sd0, 6'd0, 6'd0},
            '{ROW_ITEM,  OP_READ, 8'd0,   8'd0,   12'd0,    12'd0,    1'b1, 1'b0,
              47'sd0, 6'd0, 6'd0},
            '{ROW_MEANS, OP_LOAD, 8'd0,   8'd0,   12'd4095, 12'd4095, 1'b0, 1'b0,
              47'sd0, 6'd0, 6'd0},
            '{ROW_FILL,  OP_LOAD, 8'd0,   8'd0,   12'd0,    12'd0,    1'b0, 1'b0,
              47'sd0, 6'd0, 6'd0},
            '{ROW_ITEM,  OP_READ, 8'd0,   8'd0,   12'd0,    12'd0,    1'b1, 1'b1,
              47'sd68685926400, 6'd0, 6'd0},
            '{ROW_ITEM,  OP_READ, 8'd0,   8'd0,   12'd0,    12'd0,    1'b1, 1'b1,
              47'sd137371852800, 6'd0, 6'd1},
            '{ROW_ITEM,  OP_LOAD, 8'd255, 8'd0,   12'd0,    12'd0,    1'b0, 1'b0,
              47'sd0, 6'd0, 6'd0},
            '{ROW_ITEM,  OP_LOAD, 8'd0,   8'd255, 12'd0,    12'd0,    1'b0, 1'b0,
              47'sd0, 6'd0, 6'd0}
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            case (r.kind)
                ROW_MEANS: set_means(r.ma, r.mb);
                ROW_FILL: begin
                    while (!pair_ready) send_checked(OP_LOAD, r.pa, r.pb);
                end
                default: begin
                    send_item(r.op, r.pa, r.pb, got, e);
                    if (r.typed) begin
                        if (r.has_result) pending_entries.push_back('{r.value, r.row, r.col, 1'b0});
                    end else if (got) begin
                        pending_entries.push_back(e);
                    end
                end
            endcase
        end

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    idle_pct = 0;
                    stall_pct = 0;
                    set_means(12'd0, 12'd4095);
                end
                1: begin
                    idle_pct = 75;
                    stall_pct = 0;
                    set_means(12'd4095, 12'd0);
                end
                2: begin
                    idle_pct = 0;
                    stall_pct = 75;
                    set_means(MEAN_W'($urandom), MEAN_W'($urandom));
                end
                default: begin
                    idle_pct = 8;
                    stall_pct = 8;
                    set_means(MEAN_W'($urandom), MEAN_W'($urandom));
                end
            endcase

            // Fill a window pair, with the odd early read that must return nothing.
            send_checked(OP_LOAD, pick_pixel(), pick_pixel());
            while (!pair_ready) begin
                if ($urandom_range(49) == 0) send_checked(OP_READ, pick_pixel(), pick_pixel());
                send_checked(OP_LOAD, pick_pixel(), pick_pixel());
            end

            // The long first run crosses into row 1 and the zero last column.
            n_reads = (p == 0) ? 70 : 14;
            for (int j = 0; j < n_reads; j++) begin
                if (j == n_reads / 2) set_means(MEAN_W'($urandom), MEAN_W'($urandom));
                send_checked(OP_READ, pick_pixel(), pick_pixel());
            end
        end

        wait_idle();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
